// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and control types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int KEY_W     = 16;
  localparam int PID_W     = 16;

  localparam logic [1:0] ACT_ENQ  = 2'd0;
  localparam logic [1:0] ACT_DEQ  = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic {
    CTL_IDLE,
    CTL_HOLD
  } ctl_state_t;

  typedef struct packed {
    logic       exec;
    logic       enq;
    logic       deq;
    logic       show_head;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

// ===== src/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: accepts requests, decodes the action, sets the
// status code and drives the datapath commands.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] action,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  dp_stat_t   stat,
  output cmd_t       cmd
);

  ctl_state_t state_r, state_nxt;
  logic       accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CTL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      CTL_IDLE: begin
        in_tready = 1'b1;
      end
      CTL_HOLD: begin
        out_tvalid = 1'b1;
        in_tready  = out_tready;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
    accept = in_tvalid && in_tready;
    if (accept) begin
      state_nxt = CTL_HOLD;
    end else if (state_r == CTL_HOLD && out_tready) begin
      state_nxt = CTL_IDLE;
    end

    cmd           = '0;
    cmd.exec      = accept;
    cmd.status    = ST_OK;
    case (action)
      ACT_ENQ: begin
        if (!stat.empty && stat.full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.enq = accept;
        end
      end
      ACT_DEQ: begin
        if (stat.empty) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.deq       = accept;
          cmd.show_head = 1'b1;
        end
      end
      ACT_PEEK: begin
        if (stat.empty) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.show_head = 1'b1;
        end
      end
      default: begin
        cmd.status = ST_OK;
      end
    endcase
  end

endmodule

// ===== src/spq_dpath.sv =====
// ----------------------------------------------------------------------------
// spq_dpath
// Row of compare-and-shift cells holding the queue compacted from cell 0,
// window indices, and the result register.
// ----------------------------------------------------------------------------
module spq_dpath import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  logic [PID_W-1:0] in_pid,
  input  logic [KEY_W-1:0] in_key,
  output dp_stat_t         stat,
  output logic [1:0]       res_status,
  output logic [PID_W-1:0] res_pid,
  output logic [KEY_W-1:0] res_key
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [PID_W-1:0] pid_r [DEPTH];
  logic [KEY_W-1:0] key_r [DEPTH];
  logic [IW-1:0]    head_r, tail_r, cnt;
  logic             empty_r;
  logic [DEPTH-1:0] keep;
  logic [DEPTH-1:0] prev_keep;

  assign cnt        = tail_r - head_r;
  assign stat.empty = empty_r;
  assign stat.full  = (tail_r == IW'(DEPTH - 1));
  assign prev_keep  = {keep[DEPTH-2:0], 1'b1};

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [PID_W-1:0] pid_below, pid_above;
      logic [KEY_W-1:0] key_below, key_above;

      assign keep[g] = !empty_r && (IW'(g) <= cnt) && (key_r[g] <= in_key);

      if (g == 0) begin : g_first
        assign pid_below = in_pid;
        assign key_below = in_key;
      end else begin : g_mid
        assign pid_below = pid_r[g-1];
        assign key_below = key_r[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
        assign pid_above = pid_r[g];
        assign key_above = key_r[g];
      end else begin : g_inner
        assign pid_above = pid_r[g+1];
        assign key_above = key_r[g+1];
      end

      always_ff @(posedge clk) begin
        if (cmd.enq) begin
          if (!keep[g]) begin
            if (prev_keep[g]) begin
              pid_r[g] <= in_pid;
              key_r[g] <= in_key;
            end else begin
              pid_r[g] <= pid_below;
              key_r[g] <= key_below;
            end
          end
        end else if (cmd.deq) begin
          pid_r[g] <= pid_above;
          key_r[g] <= key_above;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else if (cmd.enq) begin
      if (empty_r) begin
        head_r  <= '0;
        tail_r  <= '0;
        empty_r <= 1'b0;
      end else begin
        tail_r <= tail_r + IW'(1);
      end
    end else if (cmd.deq) begin
      if (head_r == tail_r) begin
        head_r  <= '0;
        tail_r  <= '0;
        empty_r <= 1'b1;
      end else begin
        head_r <= head_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= cmd.status;
      res_pid    <= cmd.show_head ? pid_r[0] : '0;
      res_key    <= cmd.show_head ? key_r[0] : '0;
    end
  end

endmodule

// ===== src/sorted_priority_queue.sv =====
// Result: registered, and valid in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken at once; the cell
// row inserts or shifts in one step, and a new request enters only when no
// result waits or the waiting result is taken in the same cycle.
// Reset: synchronous, active low; the queue comes up empty with both indices
// at zero. Entry contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue of process entries ordered by start time, with stable
// insertion among equal keys and a linear slot window.
// ----------------------------------------------------------------------------
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // process_id[15:0], start_time[31:16]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // head_process[15:0], head_start[31:16]
  output logic [1:0]  out_tuser   // status[1:0]
);

  cmd_t             cmd;
  dp_stat_t         stat;
  logic [PID_W-1:0] res_pid;
  logic [KEY_W-1:0] res_key;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .action     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  spq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_pid     (in_tdata[15:0]),
    .in_key     (in_tdata[31:16]),
    .stat       (stat),
    .res_status (out_tuser),
    .res_pid    (res_pid),
    .res_key    (res_key)
  );

  assign out_tdata = {res_key, res_pid};

  a_empty_no_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tdata == '0)
    else $error("empty status with nonzero head fields");

  a_full_no_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> out_tdata == '0)
    else $error("full status with nonzero head fields");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("undefined status code");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule
